>>> sv/jsrr_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil relaxation package
// Field widths, register indexes, reset values and the per-cell tag type
// used by the stencil block; the line store RAM does not depend on it.
// ----------------------------------------------------------------------------
package jsrr_pkg;

    // Field widths
    localparam int CELL_W     = 32;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 16;
    localparam int RES_W      = 63;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    // Register reset values and the smallest legal grid dimensions
    localparam logic [COL_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [COL_W-1:0] WIDTH_MIN    = 11'd3;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd1024;
    localparam logic [ROW_W-1:0] HEIGHT_MIN   = 16'd3;

    // Saturation ceiling of the residual sum
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    // Per-cell flags that travel down the pipeline with each cell
    typedef struct packed {
        logic prod;   // cell relaxes an interior cell and gives a result
        logic last;   // result belongs to the final interior cell
        logic clear;  // cell closes the grid, residual restarts afterwards
    } t_tag;

endpackage

>>> sv/jsrr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read and holds until the next read. A read
// and a write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module jsrr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/jacobi_stencil_relax_residual.sv
// ----------------------------------------------------------------------------
// Jacobi 5-point stencil relaxation with running residual
// Streams grid cells in raster order, relaxes every interior cell to the
// mean of its four neighbours and keeps a saturating sum of squared changes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------
//  cfg     | in        | i_cfg_we                | i_cfg_addr, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall | i_cell_value
//  out     | out       | o_out_valid / i_out_stall | o_new_value, o_residual_sum,
//          |           |                         | o_last_of_grid
//
//  One cell is taken every cycle while o_in_stall is low; the line store
//  RAM is read once and written once per cell.
//  A result passes through stages one to three into the output register.
//  Reset is synchronous and active low; the line stores are not cleared,
//  their unwritten entries only feed the first two rows, which give nothing.
//  Each pipeline stage holds under an output stall only while the stage
//  after it is full, so bubbles close up before input transfers stop.
// ----------------------------------------------------------------------------
module jacobi_stencil_relax_residual #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jsrr_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [jsrr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [jsrr_pkg::CELL_W-1:0]  i_cell_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [jsrr_pkg::CELL_W-1:0]  o_new_value,
    output logic [jsrr_pkg::RES_W-1:0]          o_residual_sum,
    output logic                                o_last_of_grid
);

    localparam int AW     = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
    localparam int WCAP   = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int CW     = jsrr_pkg::CELL_W;
    localparam int COLW   = jsrr_pkg::COL_W;
    localparam int ROWW   = jsrr_pkg::ROW_W;
    localparam int RESW   = jsrr_pkg::RES_W;
    localparam logic [AW-1:0]   IDX_TOP   = AW'(MAX_WIDTH - 1);
    localparam logic [COLW-1:0] WIDTH_CAP = COLW'(WCAP);

    // Configuration registers
    logic [COLW-1:0] r_grid_width;
    logic [ROWW-1:0] r_grid_height;

    // Raster position of the next cell
    logic [COLW-1:0] r_col;
    logic [ROWW-1:0] r_row;

    // Stage one: cell waiting for its line store read
    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_x;
    logic [AW-1:0]     r_s1_idx;
    jsrr_pkg::t_tag    r_s1_tag;
    logic              r_fwd;
    logic [2*CW-1:0]   r_fwd_data;

    // Window state: two entries of the row above, top neighbour, left cell
    logic [CW-1:0]     r_w1;
    logic [CW-1:0]     r_w2;
    logic [CW-1:0]     r_top;
    logic [CW-1:0]     r_prev;

    // Stage two: new value and size of the change
    logic              r_s2_valid;
    logic [CW-1:0]     r_s2_nv;
    logic [CW-1:0]     r_s2_mag;
    jsrr_pkg::t_tag    r_s2_tag;

    // Stage three: squared change
    logic              r_s3_valid;
    logic [CW-1:0]     r_s3_nv;
    logic [2*CW-1:0]   r_s3_sq;
    jsrr_pkg::t_tag    r_s3_tag;

    // Residual accumulator and output register
    logic [RESW-1:0]   r_acc;
    logic              r_out_valid;
    logic [CW-1:0]     r_out_nv;
    logic [RESW-1:0]   r_out_res;
    logic              r_out_last;

    logic [COLW-1:0]   w_eff;
    logic [ROWW-1:0]   h_eff;
    logic [COLW:0]     n_col;
    logic [ROWW:0]     n_row;
    logic              row_end;
    logic              grid_end;
    jsrr_pkg::t_tag    in_tag;
    logic [AW-1:0]     in_idx;

    logic              out_free;
    logic              s3_adv;
    logic              s2_adv;
    logic              s1_adv;
    logic              in_acc;
    logic              fwd_hit;

    logic [2*CW-1:0]   ram_rdata;
    logic [2*CW-1:0]   s1_rd;
    logic [CW-1:0]     s1_above;
    logic [CW-1:0]     s1_two;
    logic [2*CW-1:0]   s1_wdata;
    logic [CW+1:0]     s1_sum;
    logic [CW-1:0]     n_nv;
    logic [CW:0]       s1_diff;
    logic [CW:0]       s1_neg;
    logic [CW-1:0]     n_mag;

    logic [RESW+1:0]   acc_sum;
    logic [RESW-1:0]   n_res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= jsrr_pkg::WIDTH_RESET;
            r_grid_height <= jsrr_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                jsrr_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[COLW-1:0];
                jsrr_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid size, clamped to the supported range
    always_comb begin
        if (r_grid_width < jsrr_pkg::WIDTH_MIN) begin
            w_eff = jsrr_pkg::WIDTH_MIN;
        end else if (r_grid_width > WIDTH_CAP) begin
            w_eff = WIDTH_CAP;
        end else begin
            w_eff = r_grid_width;
        end
        h_eff = (r_grid_height < jsrr_pkg::HEIGHT_MIN) ? jsrr_pkg::HEIGHT_MIN
                                                       : r_grid_height;
    end

    // Position decode for the incoming cell
    always_comb begin
        n_col        = {1'b0, r_col} + 1'b1;
        n_row        = {1'b0, r_row} + 1'b1;
        row_end      = n_col >= {1'b0, w_eff};
        grid_end     = row_end && (n_row >= {1'b0, h_eff});
        in_tag.prod  = (r_row >= 16'd2) && (r_col >= 11'd2) &&
                       (r_row < h_eff) && (r_col < w_eff);
        in_tag.last  = (n_row == {1'b0, h_eff}) && (n_col == {1'b0, w_eff});
        in_tag.clear = grid_end;
        in_idx       = (32'(r_col) < MAX_WIDTH) ? AW'(r_col) : IDX_TOP;
    end

    // Pipeline flow: each stage moves when the one after it has room
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s3_adv     = r_s3_valid && (!r_s3_tag.prod || out_free);
    assign s2_adv     = r_s2_valid && (!r_s3_valid || s3_adv);
    assign s1_adv     = r_s1_valid && (!r_s2_valid || s2_adv);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Raster counters advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= grid_end ? '0 : n_row[ROWW-1:0];
            end else begin
                r_col <= n_col[COLW-1:0];
            end
        end
    end

    // Line store entry: two rows above in the upper half, row above below
    jsrr_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_idx),
        .i_wdata (s1_wdata),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // A write and a read of the same entry in one cycle bypass the RAM
    assign fwd_hit = s1_adv && (r_s1_idx == in_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_fwd      <= fwd_hit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x     <= i_cell_value;
            r_s1_idx   <= in_idx;
            r_s1_tag   <= in_tag;
            r_fwd_data <= s1_wdata;
        end
    end

    // Stage one: stencil sum, floor of a quarter, change against the centre
    always_comb begin
        s1_rd    = r_fwd ? r_fwd_data : ram_rdata;
        s1_above = s1_rd[CW-1:0];
        s1_two   = s1_rd[2*CW-1:CW];
        s1_wdata = {s1_above, r_s1_x};
        s1_sum   = {{2{r_w1[CW-1]}}, r_w1} + {{2{s1_above[CW-1]}}, s1_above}
                 + {{2{r_top[CW-1]}}, r_top} + {{2{r_prev[CW-1]}}, r_prev};
        n_nv     = s1_sum[CW+1:2];
        s1_diff  = {n_nv[CW-1], n_nv} - {r_w2[CW-1], r_w2};
        s1_neg   = (CW+1)'(0) - s1_diff;
        n_mag    = s1_diff[CW] ? s1_neg[CW-1:0] : s1_diff[CW-1:0];
    end

    // Window state is committed as the cell leaves stage one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1   <= '0;
            r_w2   <= '0;
            r_top  <= '0;
            r_prev <= '0;
        end else if (s1_adv) begin
            r_w1   <= r_w2;
            r_w2   <= s1_above;
            r_top  <= s1_two;
            r_prev <= r_s1_x;
        end
    end

    // Stage two register; cells with nothing left to do are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!r_s2_valid || s2_adv) begin
            r_s2_valid <= s1_adv && (r_s1_tag.prod || r_s1_tag.clear);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_nv  <= n_nv;
            r_s2_mag <= n_mag;
            r_s2_tag <= r_s1_tag;
        end
    end

    // Stage three: square of the change
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (!r_s3_valid || s3_adv) begin
            r_s3_valid <= s2_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s3_nv  <= r_s2_nv;
            r_s3_sq  <= r_s2_mag * r_s2_mag;
            r_s3_tag <= r_s2_tag;
        end
    end

    // Saturating accumulation of the residual
    always_comb begin
        acc_sum = {2'b00, r_acc} + {1'b0, r_s3_sq};
        n_res   = (acc_sum > {2'b00, jsrr_pkg::RES_MAX}) ? jsrr_pkg::RES_MAX
                                                        : acc_sum[RESW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (s3_adv) begin
            r_acc <= r_s3_tag.clear ? '0 : n_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s3_adv && r_s3_tag.prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv && r_s3_tag.prod && out_free) begin
            r_out_nv   <= r_s3_nv;
            r_out_res  <= n_res;
            r_out_last <= r_s3_tag.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_value    = r_out_nv;
    assign o_residual_sum = r_out_res;
    assign o_last_of_grid = r_out_last;

    // The final interior cell always closes its grid
    a_last_closes_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_tag.last) |-> r_s3_tag.clear)
        else $error("last interior cell does not close the grid");

    // The residual restarts from zero after a grid closes
    a_residual_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_adv && r_s3_tag.clear) |=> (r_acc == '0))
        else $error("residual not cleared at end of grid");

    // A same-entry read under a write must take the bypass path
    a_bypass_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s1_adv && (r_s1_idx == in_idx)) |=> (r_fwd && r_s1_valid))
        else $error("line store hazard not bypassed");

endmodule
